[rtl/cto_pkg.sv]
// Package for the constraint topological order block.
// Holds the payload structs, the function and status codes, the controller
// state type and the command and status structs. Depends on nothing.
package cto_pkg;

  // Field widths fixed by the transaction format.
  localparam int NodeW   = 5;
  localparam int PosW    = 5;
  localparam int StatusW = 2;
  localparam int FuncW   = 2;
  localparam int CfgW    = 6;

  // Function codes of an input transaction.
  localparam logic [FuncW-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RUN   = 2'd2;

  // Status codes of a result transaction.
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RANGE    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NO_ORDER = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [NodeW-1:0] first_node;
    logic [NodeW-1:0] second_node;
  } in_t;

  typedef struct packed {
    logic [NodeW-1:0]   node;
    logic [PosW-1:0]    position;
    logic [StatusW-1:0] status;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CLOSE,
    S_SCAN,
    S_PICK,
    S_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               cons_clear;
    logic               cons_add;
    logic               clo_load;
    logic               clo_step;
    logic               scan;
    logic               place;
    logic               cnt_clr;
    logic               cnt_inc;
    logic               placed_clr;
    logic               out_load_err;
    logic [StatusW-1:0] err_status;
    logic               out_load_node;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             add_ok;
    logic             k_last;
    logic             any_empty;
    logic             all_placed;
  } sts_t;

endpackage

[rtl/cto_dpath.sv]
// Datapath of the constraint topological order block.
// Holds the constraint and closure matrices, the order memory, counters and
// the result register. Depends on cto_pkg.
module cto_dpath #(
  parameter int MAX_NODES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cto_pkg::in_t                in_data_i,
  input  logic                        cfg_we_i,
  input  logic [cto_pkg::CfgW-1:0]    cfg_data_i,
  input  cto_pkg::cmd_t               cmd_i,
  output cto_pkg::sts_t               sts_o,
  output cto_pkg::out_t               out_data_o
);
  import cto_pkg::*;

  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = (NW > CfgW) ? NW : CfgW;
  localparam logic [CW-1:0] MaxC = CW'(MAX_NODES);

  logic [CfgW-1:0]      node_count_q;
  logic [NW-1:0]        n_act;
  logic [MAX_NODES-1:0] act_mask;
  logic [MAX_NODES-1:0] cons_q [MAX_NODES];
  logic [MAX_NODES-1:0] clo_q  [MAX_NODES];
  logic [MAX_NODES-1:0] empty_q;
  logic [IW-1:0]        order_mem [MAX_NODES];
  logic [NW-1:0]        cnt_q;
  logic [NW-1:0]        placed_q;
  logic [MAX_NODES-1:0] row_k;
  logic [IW-1:0]        k_idx;
  logic [IW-1:0]        sel;
  logic [MAX_NODES-1:0] sel_hot;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        a_idx;
  logic [IW-1:0]        b_idx;
  logic                 k_last;
  out_t                 out_q;

  // Node count register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // Active node count: zero reads as one, large values saturate.
  always_comb begin
    if (node_count_q == '0) begin
      n_act = NW'(1);
    end else if (CW'(node_count_q) > MaxC) begin
      n_act = NW'(MAX_NODES);
    end else begin
      n_act = NW'(node_count_q);
    end
  end

  // One mask bit per node below the active count.
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      act_mask[i] = (CW'(i) < CW'(n_act));
    end
  end

  assign a_idx   = IW'(in_data_i.first_node);
  assign b_idx   = IW'(in_data_i.second_node);
  assign k_idx   = IW'(cnt_q);
  assign row_k   = clo_q[k_idx];
  assign k_last  = (cnt_q == n_act - NW'(1));
  assign rd_addr = IW'(n_act - NW'(1) - cnt_q);

  // Constraint matrix: cleared as a whole or set one bit at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        cons_q[i] <= '0;
      end
    end else if (cmd_i.cons_clear) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        cons_q[i] <= '0;
      end
    end else if (cmd_i.cons_add) begin
      cons_q[a_idx][b_idx] <= 1'b1;
    end
  end

  // Lowest empty row among the registered scan flags.
  always_comb begin
    sel = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (empty_q[i]) begin
        sel = IW'(i);
      end
    end
    sel_hot = {{(MAX_NODES - 1){1'b0}}, 1'b1} << sel;
  end

  // Closure matrix: load, shared step on each row reaching the pivot, pick.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clo_load) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        clo_q[i] <= act_mask[i] ? (cons_q[i] & act_mask) : '0;
      end
    end else if (cmd_i.clo_step) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        if (clo_q[i][k_idx]) begin
          clo_q[i] <= clo_q[i] | row_k;
        end
      end
    end else if (cmd_i.place) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        clo_q[j] <= (clo_q[j] & ~sel_hot) | ((IW'(j) == sel) ? sel_hot : '0);
      end
    end
  end

  // Empty-row flags, taken from the closure matrix in a scan cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        empty_q[i] <= act_mask[i] && (clo_q[i] == '0);
      end
    end
  end

  // Order memory: one write per placed node.
  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      order_mem[IW'(placed_q)] <= sel;
    end
  end

  // Step counter for closure steps and result positions; placed count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      placed_q <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + NW'(1);
      end
      if (cmd_i.placed_clr) begin
        placed_q <= '0;
      end else if (cmd_i.place) begin
        placed_q <= placed_q + NW'(1);
      end
    end
  end

  // Result register, loaded with an error or with a node read from the order memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_err) begin
      out_q.node     <= '0;
      out_q.position <= '0;
      out_q.status   <= cmd_i.err_status;
      out_q.last     <= 1'b1;
    end else if (cmd_i.out_load_node) begin
      out_q.node     <= NodeW'(order_mem[rd_addr]);
      out_q.position <= PosW'(cnt_q);
      out_q.status   <= STATUS_OK;
      out_q.last     <= k_last;
    end
  end

  assign out_data_o = out_q;

  // Status back to the controller.
  always_comb begin
    sts_o.func       = in_data_i.func;
    sts_o.add_ok     = (CW'(in_data_i.first_node) < CW'(n_act)) &&
                       (CW'(in_data_i.second_node) < CW'(n_act));
    sts_o.k_last     = k_last;
    sts_o.any_empty  = |empty_q;
    sts_o.all_placed = (placed_q == n_act);
  end

  // A node is placed at most once per active node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> (placed_q < n_act))
    else $error("placed count would pass the active node count");

  // Scan flags never mark a row outside the active nodes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> ((empty_q & ~act_mask) == '0))
    else $error("inactive row flagged as empty");

endmodule

[rtl/cto_ctrl.sv]
// Controller of the constraint topological order block.
// Sequences load, closure, scan, pick and result phases and owns the
// handshakes. Depends on cto_pkg.
module cto_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  cto_pkg::sts_t sts_i,
  output cto_pkg::cmd_t cmd_o
);
  import cto_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        accept;

  // The result register can take new data when empty or being drained.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (sts_i.func == FUNC_RUN)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_CLOSE;
      end
      S_CLOSE: begin
        if (sts_i.k_last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (sts_i.any_empty) begin
          state_d = S_SCAN;
        end else if (sts_i.all_placed) begin
          state_d = S_EMIT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free && sts_i.k_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.err_status = STATUS_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (sts_i.func)
            FUNC_CLEAR: begin
              cmd_o.cons_clear = 1'b1;
            end
            FUNC_ADD: begin
              if (sts_i.add_ok) begin
                cmd_o.cons_add = 1'b1;
              end else begin
                cmd_o.out_load_err = 1'b1;
                cmd_o.err_status   = STATUS_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.clo_load   = 1'b1;
        cmd_o.cnt_clr    = 1'b1;
        cmd_o.placed_clr = 1'b1;
      end
      S_CLOSE: begin
        cmd_o.clo_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_PICK: begin
        if (sts_i.any_empty) begin
          cmd_o.place = 1'b1;
        end else if (sts_i.all_placed) begin
          cmd_o.cnt_clr = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load_err = 1'b1;
          cmd_o.err_status   = STATUS_NO_ORDER;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load_node = 1'b1;
          cmd_o.cnt_inc       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd_o.out_load_err || cmd_o.out_load_node) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load_err || cmd_o.out_load_node) |-> out_free)
    else $error("result register overwritten while stalled");

  // Results are emitted only after every active node was placed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && ($past(state_q) == S_PICK)) |-> $past(sts_i.all_placed))
    else $error("emit phase entered without a full order");

endmodule

[rtl/constraint_topological_order.sv]
// Top level of the constraint topological order block.
// Joins the controller cto_ctrl and the datapath cto_dpath; uses cto_pkg.
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_stall_o  in_data_i  (func, first_node, second_node)
//   result    out_valid_o/out_stall_i out_data_o (node, position, status, last)
//   config    cfg_we_i               cfg_data_i (node_count)
//
// Clear and add transactions are carried out from the idle state.
// A run loads the closure matrix, does one shared row-OR closure step per
// pivot node, then a scan and a pick per placed node and a final scan and
// pick, then gives one result per cycle while the result is not stalled.
// Reset clears the constraint matrix at once; no clearing pass follows.
// A stalled result holds; the next transaction is taken when the block is
// idle and the result register is free or being drained.
module constraint_topological_order #(
  parameter int MAX_NODES = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cto_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cto_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [cto_pkg::CfgW-1:0] cfg_data_i
);
  import cto_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cto_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cto_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
